[hdl/grw_pkg.sv]
package grw_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 6;
    localparam int DEG_W     = 7;
    localparam int CNT_W     = 32;
    localparam int PICK_W    = 15;
    localparam int PCT_W     = 7;
    localparam int NBR_AW    = 2 * NODE_W;
    localparam int DIV_STEPS = PICK_W;
    localparam int DIV_CNT_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    localparam logic [CFG_W-1:0] NUM_NODES_RST = 7'd64;
    localparam logic [CFG_W-1:0] DAMP_RST      = 7'd15;

    typedef enum logic [1:0] {
        FUNC_ADD,
        FUNC_WALK,
        FUNC_READ,
        FUNC_NONE
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_FULL,
        STAT_RANGE
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_NODES,
        CFG_DAMP
    } t_cfg_idx;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_RANGE,
        RES_FULL,
        RES_ADDED,
        RES_READ,
        RES_STEP
    } t_res_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EXEC,
        S_DIVIDE,
        S_NBR_RD,
        S_NBR_TAKE,
        S_VISIT_RD,
        S_VISIT_WR,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic      cap_in;
        logic      set_cur_a;
        logic      div_start;
        logic      next_from_rem;
        logic      next_from_nbr;
        logic      add_edge;
        logic      visit_wr;
        logic      res_set;
        t_res_kind res_kind;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  restart;
        logic  a_bad;
        logic  b_bad;
        logic  deg_full;
        logic  take_nbr;
        logic  div_done;
    } t_dp_status;

endpackage

[hdl/grw_divmod.sv]
module grw_divmod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [grw_pkg::PICK_W-1:0]  i_dividend,
    input  logic [grw_pkg::DEG_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [grw_pkg::NODE_W-1:0]  o_rem
);
    import grw_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PICK_W-1:0]    r_dvd;
    logic [DEG_W-1:0]     r_dvs;
    logic [DEG_W-1:0]     r_rem;
    logic [DEG_W-1:0]     trial;
    logic [DEG_W-1:0]     n_rem;

    always_comb begin
        trial = {r_rem[DEG_W-2:0], r_dvd[PICK_W-1]};
        if (trial >= r_dvs) begin
            n_rem = trial - r_dvs;
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[PICK_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[NODE_W-1:0];

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (!r_busy && i_divisor != '0))
        else $error("divider started while busy or with zero divisor");
`endif

endmodule

[hdl/grw_datapath.sv]
module grw_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [grw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [grw_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic [1:0]                    i_func,
    input  logic [grw_pkg::NODE_W-1:0]    i_node_a,
    input  logic [grw_pkg::NODE_W-1:0]    i_node_b,
    input  logic                          i_restart,
    input  logic [grw_pkg::PCT_W-1:0]     i_coin,
    input  logic [grw_pkg::PICK_W-1:0]    i_pick,
    input  grw_pkg::t_dp_cmd              i_cmd,
    output grw_pkg::t_dp_status           o_sts,
    output logic [1:0]                    o_status,
    output logic [grw_pkg::NODE_W-1:0]    o_node,
    output logic [grw_pkg::CNT_W-1:0]     o_visits
);
    import grw_pkg::*;

    logic [CFG_W-1:0]  r_num_nodes;
    logic [CFG_W-1:0]  r_damp;
    logic [DEG_W-1:0]  lim;

    t_func             r_func;
    logic [NODE_W-1:0] r_a;
    logic [NODE_W-1:0] r_b;
    logic              r_restart;
    logic [PCT_W-1:0]  r_coin;
    logic [PICK_W-1:0] r_pick;
    logic [NODE_W-1:0] r_cur;
    logic [NODE_W-1:0] r_next;
    logic              r_take_nbr;

    logic [DEG_W-1:0]  deg_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_deg_vld;
    logic [DEG_W-1:0]  r_deg_q;
    logic              r_deg_vld_q;
    logic [NODE_W-1:0] deg_addr;
    logic [DEG_W-1:0]  deg_cur;

    logic [CNT_W-1:0]  vc_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_vc_vld;
    logic [CNT_W-1:0]  r_vc_q;
    logic              r_vc_vld_q;
    logic [NODE_W-1:0] vc_addr;
    logic [CNT_W-1:0]  vc_cur;
    logic [CNT_W-1:0]  vc_inc;

    logic [NODE_W-1:0] nbr_mem [2**NBR_AW];
    logic [NODE_W-1:0] r_nbr_q;

    t_status           r_res_st;
    logic [NODE_W-1:0] r_res_node;
    logic [CNT_W-1:0]  r_res_vis;

    logic              take_nbr_c;
    logic              deg_full;
    logic              div_done;
    logic [NODE_W-1:0] div_rem;
    logic [DEG_W-1:0]  div_divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes <= NUM_NODES_RST;
            r_damp      <= DAMP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_NODES: r_num_nodes <= i_cfg_wdata;
                CFG_DAMP:      r_damp      <= i_cfg_wdata;
                default:       r_damp      <= r_damp;
            endcase
        end
    end

    always_comb begin
        if (r_num_nodes == '0) begin
            lim = DEG_W'(1);
        end else if (r_num_nodes > CFG_W'(MAX_NODES)) begin
            lim = DEG_W'(MAX_NODES);
        end else begin
            lim = r_num_nodes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_func    <= t_func'(i_func);
            r_a       <= i_node_a;
            r_b       <= i_node_b;
            r_restart <= i_restart;
            r_coin    <= i_coin;
            r_pick    <= i_pick;
        end
        if (i_cmd.div_start) begin
            r_take_nbr <= take_nbr_c;
        end
        if (i_cmd.next_from_rem) begin
            r_next <= div_rem;
        end else if (i_cmd.next_from_nbr) begin
            r_next <= r_nbr_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (i_cmd.set_cur_a) begin
            r_cur <= r_a;
        end else if (i_cmd.visit_wr) begin
            r_cur <= r_next;
        end
    end

    assign deg_addr = (r_func == FUNC_ADD) ? r_a : r_cur;
    assign vc_addr  = (r_func == FUNC_READ) ? r_a : r_next;
    assign deg_cur  = r_deg_vld_q ? r_deg_q : '0;
    assign vc_cur   = r_vc_vld_q ? r_vc_q : '0;
    assign vc_inc   = (&vc_cur) ? vc_cur : vc_cur + 1'b1;
    assign deg_full = (deg_cur >= DEG_W'(MAX_NODES));
    assign take_nbr_c = (r_coin > r_damp) && (deg_cur != '0);
    assign div_divisor = take_nbr_c ? deg_cur : lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg_vld <= '0;
            r_vc_vld  <= '0;
        end else begin
            if (i_cmd.add_edge) begin
                r_deg_vld[r_a] <= 1'b1;
            end
            if (i_cmd.visit_wr) begin
                r_vc_vld[r_next] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_deg_q     <= deg_mem[deg_addr];
        r_deg_vld_q <= r_deg_vld[deg_addr];
        if (i_cmd.add_edge) begin
            deg_mem[r_a] <= deg_cur + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vc_q     <= vc_mem[vc_addr];
        r_vc_vld_q <= r_vc_vld[vc_addr];
        if (i_cmd.visit_wr) begin
            vc_mem[r_next] <= vc_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nbr_q <= nbr_mem[{r_cur, div_rem}];
        if (i_cmd.add_edge) begin
            nbr_mem[{r_a, deg_cur[NODE_W-1:0]}] <= r_b;
        end
    end

    grw_divmod u_divmod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_pick),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            case (i_cmd.res_kind)
                RES_RANGE: begin
                    r_res_st   <= STAT_RANGE;
                    r_res_node <= r_a;
                    r_res_vis  <= '0;
                end
                RES_FULL: begin
                    r_res_st   <= STAT_FULL;
                    r_res_node <= r_a;
                    r_res_vis  <= '0;
                end
                RES_ADDED: begin
                    r_res_st   <= STAT_OK;
                    r_res_node <= r_a;
                    r_res_vis  <= '0;
                end
                RES_READ: begin
                    r_res_st   <= STAT_OK;
                    r_res_node <= r_a;
                    r_res_vis  <= vc_cur;
                end
                RES_STEP: begin
                    r_res_st   <= STAT_OK;
                    r_res_node <= r_next;
                    r_res_vis  <= vc_inc;
                end
                default: begin
                    r_res_st   <= STAT_OK;
                    r_res_node <= '0;
                    r_res_vis  <= '0;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            o_status <= r_res_st;
            o_node   <= r_res_node;
            o_visits <= r_res_vis;
        end
    end

    always_comb begin
        o_sts.func     = r_func;
        o_sts.restart  = r_restart;
        o_sts.a_bad    = ({1'b0, r_a} >= lim);
        o_sts.b_bad    = ({1'b0, r_b} >= lim);
        o_sts.deg_full = deg_full;
        o_sts.take_nbr = r_take_nbr;
        o_sts.div_done = div_done;
    end

`ifndef ASSERT_OFF
    a_add_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_edge |-> !deg_full)
        else $error("edge stored into a full list");
`endif

endmodule

[hdl/grw_ctrl.sv]
module grw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_ready,
    output logic                 o_valid,
    output grw_pkg::t_dp_cmd     o_cmd,
    input  grw_pkg::t_dp_status  i_sts
);
    import grw_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.res_kind = RES_NONE;
        o_ready        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_sts.func)
                    FUNC_ADD: begin
                        if (i_sts.a_bad || i_sts.b_bad) begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_kind = RES_RANGE;
                            n_state        = S_RESULT;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                    FUNC_WALK: begin
                        if (i_sts.restart && i_sts.a_bad) begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_kind = RES_RANGE;
                            n_state        = S_RESULT;
                        end else begin
                            o_cmd.set_cur_a = i_sts.restart;
                            n_state         = S_READ;
                        end
                    end
                    FUNC_READ: begin
                        if (i_sts.a_bad) begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_kind = RES_RANGE;
                            n_state        = S_RESULT;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_kind = RES_NONE;
                        n_state        = S_RESULT;
                    end
                endcase
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                case (i_sts.func)
                    FUNC_ADD: begin
                        o_cmd.res_set = 1'b1;
                        if (i_sts.deg_full) begin
                            o_cmd.res_kind = RES_FULL;
                        end else begin
                            o_cmd.add_edge = 1'b1;
                            o_cmd.res_kind = RES_ADDED;
                        end
                        n_state = S_RESULT;
                    end
                    FUNC_WALK: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIVIDE;
                    end
                    FUNC_READ: begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_kind = RES_READ;
                        n_state        = S_RESULT;
                    end
                    default: begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_kind = RES_NONE;
                        n_state        = S_RESULT;
                    end
                endcase
            end
            S_DIVIDE: begin
                if (i_sts.div_done) begin
                    if (i_sts.take_nbr) begin
                        n_state = S_NBR_RD;
                    end else begin
                        o_cmd.next_from_rem = 1'b1;
                        n_state             = S_VISIT_RD;
                    end
                end
            end
            S_NBR_RD: begin
                n_state = S_NBR_TAKE;
            end
            S_NBR_TAKE: begin
                o_cmd.next_from_nbr = 1'b1;
                n_state             = S_VISIT_RD;
            end
            S_VISIT_RD: begin
                n_state = S_VISIT_WR;
            end
            S_VISIT_WR: begin
                o_cmd.visit_wr = 1'b1;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_kind = RES_STEP;
                n_state        = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && !i_ready) || o_cmd.out_load;
    assign o_valid     = r_out_valid;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_ready))
        else $error("result register overwritten before taken");

    a_valid_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESULT))
        else $error("result shown outside result state");
`endif

endmodule

[hdl/graph_random_walk_visit_counter_core.sv]
// Flow, input beat to result: add and read pass the check, read and
// execute states; a walk step also waits on the bit-serial modulo unit;
// a bad node or unknown function goes from check straight to result.
// One item at a time: the next beat is accepted once the result is latched.
// Reset (synchronous, active low) clears degrees, visit counts, walk node
// and config to defaults at once; neighbor memory is not cleared.
module graph_random_walk_visit_counter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [grw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [grw_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_func,
    input  logic [grw_pkg::NODE_W-1:0]    i_node_a,
    input  logic [grw_pkg::NODE_W-1:0]    i_node_b,
    input  logic                          i_restart,
    input  logic [grw_pkg::PCT_W-1:0]     i_coin,
    input  logic [grw_pkg::PICK_W-1:0]    i_pick,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [grw_pkg::NODE_W-1:0]    o_node,
    output logic [grw_pkg::CNT_W-1:0]     o_visits
);
    import grw_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status sts;

    grw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    grw_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_func      (i_func),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .i_restart   (i_restart),
        .i_coin      (i_coin),
        .i_pick      (i_pick),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_status    (o_status),
        .o_node      (o_node),
        .o_visits    (o_visits)
    );

endmodule
